// ===== sv/bfa_pkg.sv =====
// shared types, codes and helpers of the bitmap frame allocator
package bfa_pkg;

    localparam int WORD_BITS     = 64;
    localparam int PAGE_BITS     = 12;
    localparam int CNT_BITS      = 17;
    localparam int ADDR_BITS     = 48;
    localparam int OUT_ADDR_BITS = 28;
    localparam logic [CNT_BITS-1:0] CNT_MAX = 17'h1FFFF;

    typedef enum logic [2:0] {
        MODE_ALLOC_ONE  = 3'd0,
        MODE_ALLOC_RUN  = 3'd1,
        MODE_FREE       = 3'd2,
        MODE_MARK_USED  = 3'd3,
        MODE_MARK_FREE  = 3'd4,
        MODE_QUERY      = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        FS_OK           = 2'd0,
        FS_NOT_INIT     = 2'd1,
        FS_INVALID      = 2'd2,
        FS_ALREADY_FREE = 2'd3
    } free_status_t;

    typedef enum logic [1:0] {
        QS_USED = 2'd0,
        QS_FREE = 2'd1,
        QS_BAD  = 2'd2
    } query_state_t;

    typedef enum logic [0:0] {
        REG_ENABLED = 1'b0,
        REG_TOTAL   = 1'b1
    } reg_index_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ONE_RD,
        ST_ONE_CHK,
        ST_RUN_RD,
        ST_RUN_BIT,
        ST_TAKE_RD,
        ST_TAKE_WR,
        ST_FR_RD,
        ST_FR_CHK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                enabled;
        logic [CNT_BITS-1:0] frame_total;
    } cfg_t;

    function automatic logic [5:0] lowest_set(input logic [WORD_BITS-1:0] v);
        logic [5:0] idx;
        idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                idx = 6'(i);
            end
        end
        return idx;
    endfunction

endpackage

// ===== sv/bfa_req_if.sv =====
// request channel of the allocator
interface bfa_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic [47:0] phys_addr;
    logic [16:0] run_count;

    modport source (output valid, output mode, output phys_addr, output run_count, input ready);
    modport sink (input valid, input mode, input phys_addr, input run_count, output ready);
endinterface

// ===== sv/bfa_rsp_if.sv =====
// result channel of the allocator
interface bfa_rsp_if;
    logic        valid;
    logic        ready;
    logic [27:0] alloc_addr;
    logic [1:0]  status;
    logic [1:0]  query_state;
    logic [16:0] free_cnt;
    logic [16:0] used_cnt;

    modport source (output valid, output alloc_addr, output status, output query_state,
                    output free_cnt, output used_cnt, input ready);
    modport sink (input valid, input alloc_addr, input status, input query_state,
                  input free_cnt, input used_cnt, output ready);
endinterface

// ===== sv/bfa_regs.sv =====
// apb configuration registers of the allocator
module bfa_regs (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output bfa_pkg::cfg_t cfg
);
    import bfa_pkg::*;

    logic                enabled_reg;
    logic [CNT_BITS-1:0] total_reg;
    reg_index_t          idx;
    logic                wr;

    assign pready = 1'b1;
    assign idx    = reg_index_t'(paddr[2]);
    assign wr     = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg <= 1'b0;
            total_reg   <= 17'd65536;
        end
        else if (wr)
        begin
            case (idx)
                REG_ENABLED: enabled_reg <= pwdata[0];
                REG_TOTAL:   total_reg   <= pwdata[CNT_BITS-1:0];
                default:     enabled_reg <= enabled_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_ENABLED: prdata = {31'b0, enabled_reg};
            REG_TOTAL:   prdata = {15'b0, total_reg};
            default:     prdata = '0;
        endcase
    end

    assign cfg.enabled     = enabled_reg;
    assign cfg.frame_total = total_reg;
endmodule

// ===== sv/bfa_mem.sv =====
// bitmap word memory, one write port and one registered read port
module bfa_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [63:0]   wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [63:0]   rdata
);
    logic [63:0] mem [DEPTH];
    logic [63:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ===== sv/bfa_ctrl.sv =====
// request sequencer: clear pass, word scans, run search and read-modify-write
module bfa_ctrl #(
    parameter int MAX_FRAMES = 65536,
    parameter int NUM_WORDS  = 1024,
    parameter int WAW        = 10
) (
    input  logic           clk,
    input  logic           rst_n,
    input  bfa_pkg::cfg_t  cfg,
    bfa_req_if.sink        req,
    bfa_rsp_if.source      rsp,
    output logic           mem_we,
    output logic [WAW-1:0] mem_waddr,
    output logic [63:0]    mem_wdata,
    output logic           mem_re,
    output logic [WAW-1:0] mem_raddr,
    input  logic [63:0]    mem_rdata
);
    import bfa_pkg::*;

    localparam int FW  = WAW + 6;
    localparam int CW  = (FW + 1 > CNT_BITS) ? FW + 1 : CNT_BITS;
    localparam int WCW = CW - 6;

    state_t              state_reg, state_next;
    mode_t               mode_reg, mode_next;
    logic [CW-1:0]       frame_reg, frame_next;
    logic [CW-1:0]       start_reg, start_next;
    logic [WCW-1:0]      word_reg, word_next;
    logic [CNT_BITS-1:0] len_reg, len_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [CNT_BITS-1:0] fcnt_reg, fcnt_next;
    logic [27:0]         res_reg, res_next;
    free_status_t        stat_reg, stat_next;
    query_state_t        qs_reg, qs_next;
    logic [WAW-1:0]      clr_reg, clr_next;
    logic                ov_reg, ov_next;
    logic [27:0]         oaddr_reg;
    logic [1:0]          ostat_reg, oqs_reg;
    logic [CNT_BITS-1:0] ofree_reg, oused_reg;
    logic                load;

    logic [CW-1:0]       tot;
    logic [WCW-1:0]      nw;
    logic                addr_ok;
    logic [FW-1:0]       in_frame;
    logic                bit_val;
    logic [63:0]         fb;
    logic [5:0]          fb_idx;
    logic [FW-1:0]       one_f;
    logic [FW+11:0]      one_full;
    logic [FW+11:0]      start_full;
    logic [CNT_BITS-1:0] len_inc;
    logic [CW-1:0]       start_sel;
    logic                first_w, last_w;
    logic [5:0]          lo, hi;
    logic [63:0]         mask;
    logic [CNT_BITS-1:0] fc_dec, fc_inc, fc_sub, used;

    assign tot = (CW'(cfg.frame_total) > CW'(MAX_FRAMES)) ? CW'(MAX_FRAMES)
                                                          : CW'(cfg.frame_total);
    assign nw  = (tot[CW-1:6] == '0) ? WCW'(1) : tot[CW-1:6];

    assign addr_ok  = (req.phys_addr[11:0] == 12'd0)
                   && (req.phys_addr[47:12] < 36'(MAX_FRAMES));
    assign in_frame = req.phys_addr[12 +: FW];

    assign bit_val    = mem_rdata[frame_reg[5:0]];
    assign fb         = (word_reg == '0) ? (~mem_rdata & ~64'd1) : ~mem_rdata;
    assign fb_idx     = lowest_set(fb);
    assign one_f      = {word_reg[WAW-1:0], fb_idx};
    assign one_full   = {one_f, 12'd0};
    assign start_full = {start_reg[FW-1:0], 12'd0};
    assign len_inc    = len_reg + 17'd1;
    assign start_sel  = (len_reg == '0) ? frame_reg : start_reg;

    assign first_w = (word_reg == start_reg[CW-1:6]);
    assign last_w  = (word_reg == frame_reg[CW-1:6]);
    assign lo      = first_w ? start_reg[5:0] : 6'd0;
    assign hi      = last_w ? frame_reg[5:0] : 6'd63;
    assign mask    = ({64{1'b1}} << lo) & ({64{1'b1}} >> (6'd63 - hi));

    assign fc_dec = (fcnt_reg == '0) ? fcnt_reg : fcnt_reg - 17'd1;
    assign fc_inc = (fcnt_reg == CNT_MAX) ? fcnt_reg : fcnt_reg + 17'd1;
    assign fc_sub = (fcnt_reg > cnt_reg) ? fcnt_reg - cnt_reg : '0;
    assign used   = (tot > CW'(fcnt_reg)) ? CNT_BITS'(tot - CW'(fcnt_reg)) : '0;

    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        frame_next = frame_reg;
        start_next = start_reg;
        word_next  = word_reg;
        len_next   = len_reg;
        cnt_next   = cnt_reg;
        fcnt_next  = fcnt_reg;
        res_next   = res_reg;
        stat_next  = stat_reg;
        qs_next    = qs_reg;
        clr_next   = clr_reg;
        mem_we     = 1'b0;
        mem_waddr  = '0;
        mem_wdata  = '0;
        mem_re     = 1'b0;
        mem_raddr  = '0;
        req.ready  = 1'b0;
        load       = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '1;
                if (clr_reg == WAW'(NUM_WORDS - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    mode_next  = mode_t'(req.mode);
                    frame_next = CW'(in_frame);
                    cnt_next   = req.run_count;
                    len_next   = '0;
                    word_next  = '0;
                    res_next   = '0;
                    stat_next  = FS_OK;
                    qs_next    = QS_USED;
                    state_next = ST_DONE;
                    case (mode_t'(req.mode))
                        MODE_ALLOC_ONE:
                        begin
                            if (cfg.enabled)
                            begin
                                state_next = ST_ONE_RD;
                            end
                        end
                        MODE_ALLOC_RUN:
                        begin
                            if (cfg.enabled && req.run_count == 17'd1)
                            begin
                                state_next = ST_ONE_RD;
                            end
                            else if (cfg.enabled && req.run_count != '0)
                            begin
                                frame_next = CW'(1);
                                state_next = ST_RUN_RD;
                            end
                        end
                        MODE_FREE:
                        begin
                            if (!cfg.enabled)
                            begin
                                stat_next = FS_NOT_INIT;
                            end
                            else if (!addr_ok || in_frame == '0)
                            begin
                                stat_next = FS_INVALID;
                            end
                            else
                            begin
                                state_next = ST_FR_RD;
                            end
                        end
                        MODE_MARK_USED:
                        begin
                            if (addr_ok)
                            begin
                                state_next = ST_FR_RD;
                            end
                        end
                        MODE_MARK_FREE:
                        begin
                            if (addr_ok && in_frame != '0)
                            begin
                                state_next = ST_FR_RD;
                            end
                        end
                        MODE_QUERY:
                        begin
                            if (addr_ok)
                            begin
                                state_next = ST_FR_RD;
                            end
                            else
                            begin
                                qs_next = QS_BAD;
                            end
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_ONE_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = word_reg[WAW-1:0];
                state_next = ST_ONE_CHK;
            end
            ST_ONE_CHK:
            begin
                if (fb != '0)
                begin
                    state_next = ST_DONE;
                    if (CW'(one_f) < tot)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = word_reg[WAW-1:0];
                        mem_wdata = mem_rdata | (64'd1 << fb_idx);
                        fcnt_next = fc_dec;
                        res_next  = 28'(one_full);
                    end
                end
                else if (word_reg + 1'b1 == nw)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    word_next  = word_reg + 1'b1;
                    state_next = ST_ONE_RD;
                end
            end
            ST_RUN_RD:
            begin
                if (frame_reg >= tot)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = frame_reg[FW-1:6];
                    state_next = ST_RUN_BIT;
                end
            end
            ST_RUN_BIT:
            begin
                if (!bit_val && len_inc == cnt_reg)
                begin
                    start_next = start_sel;
                    word_next  = start_sel[CW-1:6];
                    state_next = ST_TAKE_RD;
                end
                else
                begin
                    start_next = bit_val ? start_reg : start_sel;
                    len_next   = bit_val ? '0 : len_inc;
                    frame_next = frame_reg + 1'b1;
                    if (frame_reg + 1'b1 >= tot)
                    begin
                        state_next = ST_DONE;
                    end
                    else if (frame_reg[5:0] == 6'd63)
                    begin
                        state_next = ST_RUN_RD;
                    end
                end
            end
            ST_TAKE_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = word_reg[WAW-1:0];
                state_next = ST_TAKE_WR;
            end
            ST_TAKE_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = word_reg[WAW-1:0];
                mem_wdata = mem_rdata | mask;
                if (last_w)
                begin
                    fcnt_next  = fc_sub;
                    res_next   = 28'(start_full);
                    state_next = ST_DONE;
                end
                else
                begin
                    word_next  = word_reg + 1'b1;
                    state_next = ST_TAKE_RD;
                end
            end
            ST_FR_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = frame_reg[FW-1:6];
                state_next = ST_FR_CHK;
            end
            ST_FR_CHK:
            begin
                mem_waddr  = frame_reg[FW-1:6];
                state_next = ST_DONE;
                case (mode_reg)
                    MODE_FREE:
                    begin
                        if (!bit_val)
                        begin
                            stat_next = FS_ALREADY_FREE;
                        end
                        else
                        begin
                            mem_we    = 1'b1;
                            mem_wdata = mem_rdata & ~(64'd1 << frame_reg[5:0]);
                            fcnt_next = fc_inc;
                        end
                    end
                    MODE_MARK_USED:
                    begin
                        if (!bit_val)
                        begin
                            mem_we    = 1'b1;
                            mem_wdata = mem_rdata | (64'd1 << frame_reg[5:0]);
                            fcnt_next = fc_dec;
                        end
                    end
                    MODE_MARK_FREE:
                    begin
                        if (bit_val)
                        begin
                            mem_we    = 1'b1;
                            mem_wdata = mem_rdata & ~(64'd1 << frame_reg[5:0]);
                            fcnt_next = fc_inc;
                        end
                    end
                    MODE_QUERY:
                    begin
                        qs_next = bit_val ? QS_USED : QS_FREE;
                    end
                    default:
                    begin
                        qs_next = qs_reg;
                    end
                endcase
            end
            ST_DONE:
            begin
                if (!ov_reg || rsp.ready)
                begin
                    load       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign ov_next = load ? 1'b1 : (rsp.ready ? 1'b0 : ov_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            fcnt_reg  <= '0;
            clr_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fcnt_reg  <= fcnt_next;
            clr_reg   <= clr_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg  <= mode_next;
        frame_reg <= frame_next;
        start_reg <= start_next;
        word_reg  <= word_next;
        len_reg   <= len_next;
        cnt_reg   <= cnt_next;
        res_reg   <= res_next;
        stat_reg  <= stat_next;
        qs_reg    <= qs_next;
        if (load)
        begin
            oaddr_reg <= res_reg;
            ostat_reg <= stat_reg;
            oqs_reg   <= qs_reg;
            ofree_reg <= fcnt_reg;
            oused_reg <= used;
        end
    end

    assign rsp.valid       = ov_reg;
    assign rsp.alloc_addr  = oaddr_reg;
    assign rsp.status      = ostat_reg;
    assign rsp.query_state = oqs_reg;
    assign rsp.free_cnt    = ofree_reg;
    assign rsp.used_cnt    = oused_reg;
endmodule

// ===== sv/bitmap_frame_allocator.sv =====
// bitmap frame allocator top level
// free, mark and query items do at most one read of a bitmap word and one write back
// single alloc reads and checks bitmap words in turn until one has a free bit, up to MAX_FRAMES/64 words
// contiguous alloc walks one frame per cycle, pausing to read each new word, then reads and writes each word taken
// the result register lets the result wait while the next item is accepted
// after reset a clearing pass sets all MAX_FRAMES/64 words to used, one per cycle, no item taken
module bitmap_frame_allocator #(
    parameter int MAX_FRAMES = 65536
) (
    input  logic        clk,
    input  logic        rst_n,
    bfa_req_if.sink     req,
    bfa_rsp_if.source   rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import bfa_pkg::*;

    localparam int NUM_WORDS = MAX_FRAMES / WORD_BITS;
    localparam int WAW       = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

    cfg_t           cfg;
    logic           mem_we;
    logic [WAW-1:0] mem_waddr;
    logic [63:0]    mem_wdata;
    logic           mem_re;
    logic [WAW-1:0] mem_raddr;
    logic [63:0]    mem_rdata;

    bfa_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bfa_mem #(
        .DEPTH (NUM_WORDS),
        .AW    (WAW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    bfa_ctrl #(
        .MAX_FRAMES (MAX_FRAMES),
        .NUM_WORDS  (NUM_WORDS),
        .WAW        (WAW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .req       (req),
        .rsp       (rsp),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

`ifndef SYNTHESIS
    a_no_rw_collide: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we && mem_re |-> mem_waddr != mem_raddr)
        else $error("bitmap read and write hit the same word");

    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        req.ready |-> !mem_we && !mem_re)
        else $error("memory access while taking an item");

    a_status_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status != FS_OK |-> rsp.alloc_addr == '0 && rsp.query_state == QS_USED)
        else $error("free status mixed with other results");

    a_query_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.query_state != QS_USED |-> rsp.alloc_addr == '0)
        else $error("query result mixed with an allocation");
`endif
endmodule
